@@ rtl/amfi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package amfi_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_TOP_TAG   = 4'd1,
        PH_TOP_SIZE  = 4'd2,
        PH_LIST_TYPE = 4'd3,
        PH_SKIP_TOP  = 4'd4,
        PH_MOVI_TAG  = 4'd5,
        PH_MOVI_SIZE = 4'd6,
        PH_SKIP_MOVI = 4'd7
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    // Header words, big-endian as they shift in
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_AVI  = 32'h4156_4920;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_MOVI = 32'h6D6F_7669;
    localparam logic [15:0] TAG_DC   = 16'h6463;

    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = 2;
    localparam int RES_CNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] offset;
        logic [31:0] size;
        logic        last;
    } result_t;

    // Up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_push_t;

endpackage

`default_nettype wire

@@ rtl/amfi_result_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amfi_result_fifo
    import amfi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire res_push_t push,
    output logic           space_ok,
    output logic           out_valid,
    input  wire logic      out_ready,
    output result_t        out_data
);

    result_t                mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    // room for the worst case of two results from one item
    assign space_ok     = (count_reg <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

`default_nettype wire

@@ rtl/avi_movi_frame_indexer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// AVI movi frame indexer.
// Input channel (s_*): one file byte per item, s_end_of_file set on the final
// byte. Output channel (m_*): result items. Kind 0 is a frame record carrying
// the payload byte position and the chunk's size; kind 1 closes the parse
// with frames found; kind 2 flags a bad header, early end of file, a short
// LIST size or a movi list without frames. m_last_result marks the final
// result caused by one input byte (a byte causes at most two).
// Results are written to the result queue as their byte is accepted.
// Throughput: one byte per cycle while the result queue has room. The parser
// state updates in the cycle the byte is taken; results go to a 4-entry queue
// and s_ready stays high while the queue has room for two more, so a stalled
// receiver only backs up the input once three or more results are pending.
// After the closing result every further byte is accepted and dropped until
// reset. Reset (aresetn low, synchronous) returns to the header check at byte
// position zero and empties the result queue.
// POSITION_WIDTH sets the byte position counter width; positions wrap.
module avi_movi_frame_indexer
    import amfi_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_file,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [31:0]      m_frame_offset,
    output logic [31:0]      m_frame_size,
    output logic             m_last_result
);

    // list end holds position plus a 32-bit size, so one bit above the wider
    localparam int LW = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 1;

    phase_t                    phase_reg, phase_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [1:0]                idx_reg, idx_next;
    logic [31:0]               tag_reg, tag_next;
    logic [31:0]               size_reg, size_next;
    logic [32:0]               skip_reg, skip_next;
    logic [LW-1:0]             list_end_reg, list_end_next;
    logic                      seen_reg, seen_next;
    logic                      done_reg, done_next;

    logic                      accept;
    logic                      space_ok;
    res_push_t                 push;
    result_t                   out_data;

    // per-byte decisions
    logic                      word_done;
    logic [LW-1:0]             pos_ext;
    logic                      frame_emit;
    logic                      fin_sw;
    logic [1:0]                fin_sw_kind;
    logic                      eof_fin;
    logic [1:0]                eof_kind;
    logic                      movi_top;   // back at the movi loop head
    logic                      in_movi;
    result_t                   frame_res, fin_res;

    assign s_ready = space_ok;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        skip_next     = skip_reg;
        list_end_next = list_end_reg;
        seen_next     = seen_reg;
        done_next     = done_reg;
        frame_emit    = 1'b0;
        fin_sw        = 1'b0;
        fin_sw_kind   = KIND_INVALID;
        eof_fin       = 1'b0;
        eof_kind      = KIND_INVALID;
        movi_top      = 1'b0;
        in_movi       = 1'b0;
        word_done     = (idx_reg == 2'd3);
        pos_next      = pos_reg + POSITION_WIDTH'(1);
        pos_ext       = LW'(pos_next);

        // field shifters run outside the skip phases
        if (phase_reg != PH_SKIP_TOP && phase_reg != PH_SKIP_MOVI) begin
            idx_next = idx_reg + 2'd1;
            if (phase_reg == PH_TOP_SIZE || phase_reg == PH_MOVI_SIZE) begin
                size_next = {s_data_byte, size_reg[31:8]};
            end else begin
                tag_next = {tag_reg[23:0], s_data_byte};
            end
        end

        unique case (phase_reg)
            PH_HEADER: begin
                if (word_done) begin
                    if (pos_ext == LW'(4) && tag_next != TAG_RIFF) begin
                        fin_sw = 1'b1;
                    end else if (pos_ext == LW'(12)) begin
                        if (tag_next != TAG_AVI) begin
                            fin_sw = 1'b1;
                        end else begin
                            phase_next = PH_TOP_TAG;
                        end
                    end
                end
            end
            PH_TOP_TAG: begin
                if (word_done) phase_next = PH_TOP_SIZE;
            end
            PH_TOP_SIZE: begin
                if (word_done) begin
                    if (tag_next == TAG_LIST) begin
                        phase_next = PH_LIST_TYPE;
                    end else begin
                        // odd sizes carry one pad byte
                        skip_next  = {1'b0, size_next} + 33'(size_next[0]);
                        phase_next = (skip_next != '0) ? PH_SKIP_TOP : PH_TOP_TAG;
                    end
                end
            end
            PH_LIST_TYPE: begin
                if (word_done) begin
                    if (size_next < 32'd4) begin
                        fin_sw = 1'b1;
                    end else if (tag_next == TAG_MOVI) begin
                        list_end_next = pos_ext + LW'(size_next) - LW'(4);
                        movi_top      = 1'b1;
                    end else begin
                        skip_next  = {1'b0, size_next} - 33'd4;
                        phase_next = (skip_next != '0) ? PH_SKIP_TOP : PH_TOP_TAG;
                    end
                end
            end
            PH_SKIP_TOP: begin
                skip_next = skip_reg - 33'd1;
                if (skip_next == '0) phase_next = PH_TOP_TAG;
            end
            PH_MOVI_TAG: begin
                if (word_done) phase_next = PH_MOVI_SIZE;
            end
            PH_MOVI_SIZE: begin
                if (word_done) begin
                    if (tag_next[15:0] == TAG_DC) begin
                        seen_next  = 1'b1;
                        frame_emit = 1'b1;
                    end
                    // realign to an even position after the payload
                    skip_next = {1'b0, size_next} + 33'(pos_next[0] ^ size_next[0]);
                    if (skip_next == '0) begin
                        movi_top = 1'b1;
                    end else begin
                        phase_next = PH_SKIP_MOVI;
                    end
                end
            end
            PH_SKIP_MOVI: begin
                skip_next = skip_reg - 33'd1;
                if (skip_next == '0) movi_top = 1'b1;
            end
            default: begin
                fin_sw = 1'b1;
            end
        endcase

        // movi loop head: close at list end, else expect the next subchunk
        if (movi_top) begin
            if (pos_ext >= list_end_next) begin
                fin_sw      = 1'b1;
                fin_sw_kind = seen_next ? KIND_DONE : KIND_INVALID;
            end else begin
                phase_next = PH_MOVI_TAG;
            end
        end

        in_movi = (phase_next == PH_MOVI_TAG) || (phase_next == PH_MOVI_SIZE) ||
                  (phase_next == PH_SKIP_MOVI);
        if (!fin_sw && s_end_of_file) begin
            eof_fin  = 1'b1;
            eof_kind = (in_movi && seen_next) ? KIND_DONE : KIND_INVALID;
        end
        done_next = fin_sw || eof_fin;
    end

    always_comb begin
        frame_res.kind   = KIND_FRAME;
        frame_res.offset = pos_ext[31:0];
        frame_res.size   = size_next;
        frame_res.last   = !(fin_sw || eof_fin);

        fin_res.kind     = fin_sw ? fin_sw_kind : eof_kind;
        fin_res.offset   = '0;
        fin_res.size     = '0;
        fin_res.last     = 1'b1;

        push.count  = 2'd0;
        push.first  = frame_emit ? frame_res : fin_res;
        push.second = fin_res;
        if (accept && !done_reg) begin
            push.count = 2'(frame_emit) + 2'(done_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            idx_reg      <= '0;
            tag_reg      <= '0;
            size_reg     <= '0;
            skip_reg     <= '0;
            list_end_reg <= '0;
            seen_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end else if (accept && !done_reg) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            skip_reg     <= skip_next;
            list_end_reg <= list_end_next;
            seen_reg     <= seen_next;
            done_reg     <= done_next;
        end
    end

    amfi_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_result_kind  = out_data.kind;
    assign m_frame_offset = out_data.offset;
    assign m_frame_size   = out_data.size;
    assign m_last_result  = out_data.last;

endmodule

`default_nettype wire
